/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/lpsp_pkg.sv */
// Types and constants of the sensor packet speed parser.
`default_nettype none

package lpsp_pkg;

	localparam logic [7:0] START_BYTE = 8'hFA;
	localparam logic [7:0] INDEX_LOW  = 8'hA0;
	localparam logic [7:0] INDEX_HIGH = 8'hF9;
	localparam int         FOLD_SHIFT = 15;
	localparam int         WORD_W     = 16;
	localparam int         BYTE_W     = 8;
	localparam int         MAX_ACC_W  = 32;

	typedef enum logic [2:0] {
		PH_SEARCH   = 3'd0,
		PH_INDEX    = 3'd1,
		PH_SPEED_LO = 3'd2,
		PH_SPEED_HI = 3'd3,
		PH_DATA_LO  = 3'd4,
		PH_DATA_HI  = 3'd5,
		PH_SUM_LO   = 3'd6,
		PH_SUM_HI   = 3'd7
	} phase_t;

	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] speed;
	} result_t;

endpackage

`default_nettype wire

/* sv/lpsp_in_stage.sv */
// Input register stage holding one received byte for the parser.
`default_nettype none

module lpsp_in_stage (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [lpsp_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic                        advance,
	output logic                             valid_s1,
	output logic [lpsp_pkg::BYTE_W-1:0]      byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

/* sv/lpsp_parser.sv */
// Packet framing state machine with checksum accumulate and fold.
`default_nettype none

module lpsp_parser #(
	parameter int WORDS_PER_PACKET = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        valid_s1,
	input  wire logic [lpsp_pkg::BYTE_W-1:0] byte_s1,
	input  wire logic                        out_free,
	output logic                             advance,
	output lpsp_pkg::result_t                result
);

	localparam int ACC_W = (lpsp_pkg::WORD_W + WORDS_PER_PACKET > lpsp_pkg::MAX_ACC_W) ?
		lpsp_pkg::MAX_ACC_W : lpsp_pkg::WORD_W + WORDS_PER_PACKET;
	localparam int WC_W  = $clog2(WORDS_PER_PACKET + 1);
	localparam int FS    = lpsp_pkg::FOLD_SHIFT;

	lpsp_pkg::phase_t phase_q, phase_next;
	logic [ACC_W-1:0]              acc_q;
	logic [WC_W-1:0]               count_q;
	logic [WC_W-1:0]               count_inc;
	logic [lpsp_pkg::WORD_W-1:0]   speed_q;
	logic [lpsp_pkg::BYTE_W-1:0]   low_q;
	logic [lpsp_pkg::WORD_W-1:0]   word;
	logic [ACC_W-1:0]              acc_add;
	logic [ACC_W-1:0]              acc_init;
	logic [ACC_W-1:0]              fold_hi;
	logic [ACC_W-1:0]              fold_sum;
	logic [FS-1:0]                 fold;
	logic                          index_ok;
	logic                          load_low;
	logic                          load_speed;
	logic                          load_init;
	logic                          load_add;
	logic                          load_count;
	logic                          sum_match;

	assign word      = {byte_s1, low_q};
	assign acc_add   = (acc_q << 1) + ACC_W'(word);
	assign acc_init  = ACC_W'({byte_s1, lpsp_pkg::START_BYTE});
	assign fold_hi   = acc_q >> FS;
	assign fold_sum  = ACC_W'(acc_q[FS-1:0]) + fold_hi;
	assign fold      = fold_sum[FS-1:0];
	assign sum_match = ({1'b0, fold} == word);
	assign count_inc = count_q + WC_W'(1);
	assign index_ok  = byte_s1 inside {[lpsp_pkg::INDEX_LOW:lpsp_pkg::INDEX_HIGH]};

	always_comb begin
		phase_next = phase_q;
		case (phase_q)
			lpsp_pkg::PH_SEARCH: begin
				if (byte_s1 == lpsp_pkg::START_BYTE) begin
					phase_next = lpsp_pkg::PH_INDEX;
				end
			end
			lpsp_pkg::PH_INDEX: begin
				if (index_ok) begin
					phase_next = lpsp_pkg::PH_SPEED_LO;
				end else if (byte_s1 != lpsp_pkg::START_BYTE) begin
					phase_next = lpsp_pkg::PH_SEARCH;
				end
			end
			lpsp_pkg::PH_SPEED_LO: phase_next = lpsp_pkg::PH_SPEED_HI;
			lpsp_pkg::PH_SPEED_HI: phase_next = lpsp_pkg::PH_DATA_LO;
			lpsp_pkg::PH_DATA_LO:  phase_next = lpsp_pkg::PH_DATA_HI;
			lpsp_pkg::PH_DATA_HI: begin
				if (count_inc >= WC_W'(WORDS_PER_PACKET)) begin
					phase_next = lpsp_pkg::PH_SUM_LO;
				end else begin
					phase_next = lpsp_pkg::PH_DATA_LO;
				end
			end
			lpsp_pkg::PH_SUM_LO:   phase_next = lpsp_pkg::PH_SUM_HI;
			lpsp_pkg::PH_SUM_HI:   phase_next = lpsp_pkg::PH_SEARCH;
			default:               phase_next = lpsp_pkg::PH_SEARCH;
		endcase
	end

	always_comb begin
		load_low     = 1'b0;
		load_speed   = 1'b0;
		load_init    = 1'b0;
		load_add     = 1'b0;
		load_count   = 1'b0;
		result.valid = 1'b0;
		result.speed = speed_q;
		case (phase_q)
			lpsp_pkg::PH_INDEX:    load_init = index_ok;
			lpsp_pkg::PH_SPEED_LO,
			lpsp_pkg::PH_DATA_LO,
			lpsp_pkg::PH_SUM_LO:   load_low = 1'b1;
			lpsp_pkg::PH_SPEED_HI: begin
				load_speed = 1'b1;
				load_add   = 1'b1;
			end
			lpsp_pkg::PH_DATA_HI: begin
				load_add   = 1'b1;
				load_count = 1'b1;
			end
			lpsp_pkg::PH_SUM_HI:   result.valid = valid_s1 && sum_match;
			default: begin
			end
		endcase
	end

	// stall only when a result must wait for the output register
	assign advance = valid_s1 && (!result.valid || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpsp_pkg::PH_SEARCH;
			acc_q   <= '0;
			count_q <= '0;
			speed_q <= '0;
			low_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_next;
			if (load_low) begin
				low_q <= byte_s1;
			end
			if (load_speed) begin
				speed_q <= word;
				count_q <= WC_W'(2);
			end else if (load_count) begin
				count_q <= count_inc;
			end
			if (load_init) begin
				acc_q <= acc_init;
			end else if (load_add) begin
				acc_q <= acc_add;
			end else if (phase_q == lpsp_pkg::PH_SUM_HI) begin
				acc_q <= ACC_W'(fold);
			end
		end
	end

endmodule

`default_nettype wire

/* sv/lpsp_out_stage.sv */
// Result register holding one speed word until the receiver takes it.
`default_nettype none

module lpsp_out_stage (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire lpsp_pkg::result_t        result,
	output logic                          out_free,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [lpsp_pkg::WORD_W-1:0]   speed_word
);

	logic valid_q;

	assign out_free  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && result.valid) begin
			speed_word <= result.speed;
		end
	end

endmodule

`default_nettype wire

/* sv/lidar_packet_speed_parser_core.sv */
// Sensor packet parser: frames packets, checks the checksum, emits speed.
// Usage:
//   Input channel (in_valid, in_ready, rx_byte) takes one received serial byte
//   per transaction. Packets are 0xFA, an index byte 0xA0..0xF9, a little-endian
//   speed word, data words and a little-endian checksum word.
//   Output channel (out_valid, out_ready, speed_word) gives one transaction per
//   packet whose folded checksum matches; bad packets give nothing.
// Result path: the last checksum byte passes the input register, then the parser
//   checks it and the result register loads it, raising out_valid.
// Throughput: one byte per cycle unless a finished packet waits for the result
//   register (see Stall); the parser updates its state once per accepted byte.
// Stall: while the result register is full and out_ready is low, bytes that
//   do not complete a packet keep flowing; a byte that would finish a valid
//   packet waits in the input register and in_ready drops until the result
//   is taken.
// Reset: arst_n clears the valid flags of both registers and returns the parser
//   to the search for a start byte; no partial packet survives.
`default_nettype none

module lidar_packet_speed_parser_core #(
	parameter int WORDS_PER_PACKET = 10
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [lpsp_pkg::BYTE_W-1:0] rx_byte,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [lpsp_pkg::WORD_W-1:0]      speed_word
);

	logic                         valid_s1;
	logic [lpsp_pkg::BYTE_W-1:0]  byte_s1;
	logic                         advance;
	logic                         out_free;
	lpsp_pkg::result_t            result;

	lpsp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	lpsp_parser #(
		.WORDS_PER_PACKET (WORDS_PER_PACKET)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.out_free (out_free),
		.advance  (advance),
		.result   (result)
	);

	lpsp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.result     (result),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.speed_word (speed_word)
	);

endmodule

`default_nettype wire

/* sv/lpsp_checker.sv */
// Port-level checker for the packet speed parser, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module lpsp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [lpsp_pkg::WORD_W-1:0] speed_word
);

	`ASSERT_CLKD(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "out_valid dropped while stalled")
	`ASSERT_CLKD(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(speed_word), "speed_word changed while stalled")
	`ASSERT_CLKD(a_result_origin, clk, arst_n, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a byte two cycles earlier")
	`ASSERT_ALWAYS(a_ready_follows, clk, out_ready |-> in_ready, "input stalled while output drains")

endmodule

bind lidar_packet_speed_parser_core lpsp_checker u_lpsp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.speed_word (speed_word)
);

`default_nettype wire
